/* src/scv_pkg.sv */
package scv_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] MAX_RESET    = 32'd536870912;
    localparam logic [32:0] POS_MAX      = 33'h1FFFFFFFF;
    localparam logic [31:0] MAGIC        = 32'h534E5744;
    localparam logic [31:0] TAG_EPOK     = 32'h4B4F5045;
    localparam logic [31:0] TAG_FRMS     = 32'h534D5246;
    localparam logic [31:0] TAG_BODY     = 32'h59444F42;
    localparam logic [31:0] TAG_GRAV     = 32'h56415247;
    localparam logic [31:0] TAG_CLKS     = 32'h534B4C43;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_VERSION   = 4'd3,
        ST_CHECKSUM  = 4'd4,
        ST_LAYOUT    = 4'd5,
        ST_LENGTH    = 4'd6,
        ST_UNKNOWN   = 4'd7,
        ST_MISSING   = 4'd8,
        ST_DUPLICATE = 4'd9,
        ST_TOO_LARGE = 4'd10
    } status_t;

    typedef enum logic [3:0] {
        PH_FILEHDR, PH_SECHDR, PH_EPOK, PH_COUNT, PH_RECORDS, PH_SKIP,
        PH_TAIL, PH_ERR_SEC, PH_ERR_FINAL
    } phase_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [6:0] rec_size(input logic [2:0] kind);
        case (kind)
            3'd0: return 7'd32;
            3'd1: return 7'd76;
            3'd2: return 7'd124;
            3'd3: return 7'd28;
            3'd4: return 7'd56;
            default: return 7'd32;
        endcase
    endfunction

endpackage

/* src/section_container_validator_core.sv */
// Latency: the status word appears on m_tdata in the cycle after the last byte is taken.
// Throughput: one byte per cycle; s_tready drops only while a status word is held
//   and m_tready is low.
// Count bound check multiplies the 32-bit count by the record size (at most 124);
//   the CRC advances one byte per cycle in which a byte is accepted.
// Reset: synchronous active-low aresetn clears all parse state and restores the size cap.
module section_container_validator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [3:0] status, [35:4] computed_crc, [39:36] zero
);

    logic [31:0] max_reg;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [63:0] shf_reg, shf_next;
    logic [31:0] stored_reg, stored_next;
    logic [63:0] decl_reg, decl_next;
    logic [31:0] secs_reg, secs_next;
    scv_pkg::phase_t ph_reg, ph_next;
    logic [3:0]  ferr_reg, ferr_next;
    logic [31:0] tag_reg, tag_next;
    logic [63:0] send_reg, send_next;
    logic [31:0] recs_reg, recs_next;
    logic [6:0]  roff_reg, roff_next;
    logic        rails_reg, rails_next;
    logic [4:0]  seen_reg, seen_next;
    logic        req_reg, req_next;
    logic [3:0]  herr_reg, herr_next;
    logic        lay_reg, lay_next;
    logic        maj_reg, maj_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  stat;
    logic [39:0] out_reg;
    logic        oval_reg;
    logic        accept;

    assign s_tready = !oval_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = oval_reg;
    assign m_tdata  = out_reg;

    // section body remaining (nxt..end) vs count*size; products kept in 72 bits
    logic [63:0] remain;
    logic [71:0] need;

    always_comb begin
        logic [32:0] at, nxt;
        logic [6:0]  off, len;
        logic [2:0]  k;
        logic        kv;
        logic [63:0] nxt64, sum;
        logic [31:0] cnt;
        logic        carry;
        logic        fin;
        logic [63:0] fin_end;
        logic [31:0] sl;

        pos_next = pos_reg; crc_next = crc_reg; shf_next = shf_reg;
        stored_next = stored_reg; decl_next = decl_reg; secs_next = secs_reg;
        ph_next = ph_reg; ferr_next = ferr_reg; tag_next = tag_reg; send_next = send_reg;
        recs_next = recs_reg; roff_next = roff_reg; rails_next = rails_reg;
        seen_next = seen_reg; req_next = req_reg; herr_next = herr_reg; lay_next = lay_reg;
        maj_next = maj_reg; kind_next = kind_reg;
        remain = 64'd0; need = 72'd0;

        at    = pos_reg;
        nxt   = (at >= scv_pkg::POS_MAX) ? scv_pkg::POS_MAX : at + 33'd1;
        nxt64 = {31'd0, nxt};
        off   = roff_reg;
        fin   = 1'b0;
        k = 3'd0; kv = 1'b0; len = 7'd0; cnt = 32'd0; sum = 64'd0; carry = 1'b0;
        fin_end = 64'd0; sl = 32'd0;

        crc_next = scv_pkg::crc_byte(crc_reg, (at >= 33'd12 && at < 33'd16) ? 8'd0 : s_tdata);
        shf_next = {s_tdata, shf_reg[63:8]};

        if (at < scv_pkg::POS_MAX) begin
            case (ph_reg)
                scv_pkg::PH_FILEHDR: begin
                    if (at == 33'd3 && shf_next[63:32] != scv_pkg::MAGIC)
                        herr_next = scv_pkg::ST_MAGIC;
                    if (at == 33'd5 && shf_next[63:48] != 16'd1 && herr_next == 4'd0)
                        herr_next = scv_pkg::ST_VERSION;
                    if (at == 33'd11 && shf_next[63:32] != 32'd32) lay_next = 1'b1;
                    if (at == 33'd15) stored_next = shf_next[63:32];
                    if (at == 33'd23) decl_next = shf_next;
                    if (at == 33'd27) secs_next = shf_next[63:32];
                    if (at == 33'd31) begin
                        if (shf_next[63:32] != 32'd0) lay_next = 1'b1;
                        roff_next = 7'd0;
                        ph_next = (secs_reg == 32'd0) ? scv_pkg::PH_TAIL : scv_pkg::PH_SECHDR;
                    end
                end
                scv_pkg::PH_SECHDR: begin
                    roff_next = off + 7'd1;
                    if (off == 7'd3) tag_next = shf_next[63:32];
                    if (off == 7'd5) maj_next = (shf_next[63:48] == 16'd1);
                    if (off == 7'd11) req_next = shf_next[32];
                    if (off == 7'd19) begin
                        {carry, sum} = {1'b0, nxt64} + {1'b0, shf_next};
                        fin_end = carry ? 64'hFFFFFFFFFFFFFFFF : sum;
                        send_next = fin_end;
                        roff_next = 7'd0;
                        if (maj_reg) begin
                            kv = 1'b1;
                            if (tag_reg == scv_pkg::TAG_EPOK) k = 3'd0;
                            else if (tag_reg == scv_pkg::TAG_FRMS) k = 3'd1;
                            else if (tag_reg == scv_pkg::TAG_BODY) k = 3'd2;
                            else if (tag_reg == scv_pkg::TAG_GRAV) k = 3'd3;
                            else if (tag_reg == scv_pkg::TAG_CLKS) k = 3'd4;
                            else kv = 1'b0;
                        end
                        if (!kv) begin
                            if (req_reg) begin
                                ferr_next = scv_pkg::ST_UNKNOWN; ph_next = scv_pkg::PH_ERR_SEC;
                            end else if (nxt64 == fin_end) fin = 1'b1;
                            else ph_next = scv_pkg::PH_SKIP;
                        end else begin
                            kind_next = k;
                            if (seen_reg[k]) begin
                                ferr_next = scv_pkg::ST_DUPLICATE;
                                ph_next = scv_pkg::PH_ERR_SEC;
                            end else begin
                                seen_next[k] = 1'b1;
                                ph_next = (k == 3'd0) ? scv_pkg::PH_EPOK : scv_pkg::PH_COUNT;
                            end
                        end
                    end
                end
                scv_pkg::PH_EPOK: begin
                    roff_next = off + 7'd1;
                    if (off == 7'd31) begin
                        if (nxt64 == send_reg) fin = 1'b1;
                        else begin ferr_next = scv_pkg::ST_LENGTH; ph_next = scv_pkg::PH_ERR_SEC; end
                    end
                end
                scv_pkg::PH_COUNT: begin
                    roff_next = off + 7'd1;
                    if (off == 7'd3) begin
                        cnt = shf_next[63:32];
                        roff_next = 7'd0;
                        rails_next = 1'b0;
                        remain = send_reg - nxt64;
                        // count > floor(remain/size) <=> count*size > remain - remain%size
                        // <=> count*size > remain
                        need = {40'd0, cnt} * {65'd0, scv_pkg::rec_size(kind_reg)};
                        if (nxt64 <= send_reg && need > {8'd0, remain}) begin
                            ferr_next = scv_pkg::ST_LENGTH; ph_next = scv_pkg::PH_ERR_SEC;
                        end else if (cnt == 32'd0) begin
                            if (nxt64 == send_reg) fin = 1'b1;
                            else begin ferr_next = scv_pkg::ST_LENGTH; ph_next = scv_pkg::PH_ERR_SEC; end
                        end else begin
                            recs_next = cnt; ph_next = scv_pkg::PH_RECORDS;
                        end
                    end
                end
                scv_pkg::PH_RECORDS: begin
                    len = scv_pkg::rec_size(kind_reg);
                    if (kind_reg == 3'd3 && off == 7'd26) rails_next = (s_tdata != 8'd0);
                    if (kind_reg == 3'd3 && rails_next) len = 7'd100;
                    roff_next = off + 7'd1;
                    if (roff_next >= len) begin
                        roff_next = 7'd0;
                        rails_next = 1'b0;
                        recs_next = recs_reg - 32'd1;
                        if (recs_next == 32'd0) begin
                            if (nxt64 == send_reg) fin = 1'b1;
                            else begin ferr_next = scv_pkg::ST_LENGTH; ph_next = scv_pkg::PH_ERR_SEC; end
                        end
                    end
                end
                scv_pkg::PH_SKIP: begin
                    if (nxt64 >= send_reg) fin = 1'b1;
                end
                scv_pkg::PH_TAIL: begin
                    ferr_next = scv_pkg::ST_LENGTH; ph_next = scv_pkg::PH_ERR_FINAL;
                end
                default: ;
            endcase
            if (fin) begin
                roff_next = 7'd0;
                sl = (secs_reg > 32'd0) ? secs_reg - 32'd1 : 32'd0;
                secs_next = sl;
                ph_next = (sl == 32'd0) ? scv_pkg::PH_TAIL : scv_pkg::PH_SECHDR;
            end
        end
        pos_next = nxt;
    end

    // final status from the post-byte state
    always_comb begin
        logic [63:0] size;
        size = {31'd0, pos_next};
        if (size > {32'd0, max_reg}) stat = scv_pkg::ST_TOO_LARGE;
        else if (size < 64'd52) stat = scv_pkg::ST_SHORT;
        else if (herr_next != 4'd0) stat = herr_next;
        else if (lay_next || decl_next != size) stat = scv_pkg::ST_LAYOUT;
        else if (~crc_next != stored_next) stat = scv_pkg::ST_CHECKSUM;
        else begin
            case (ph_next)
                scv_pkg::PH_ERR_FINAL: stat = ferr_next;
                scv_pkg::PH_ERR_SEC:
                    stat = (size < send_next) ? scv_pkg::ST_LENGTH : ferr_next;
                scv_pkg::PH_EPOK, scv_pkg::PH_COUNT, scv_pkg::PH_RECORDS, scv_pkg::PH_SKIP:
                    stat = (size < send_next) ? scv_pkg::ST_LENGTH : scv_pkg::ST_SHORT;
                scv_pkg::PH_TAIL:
                    stat = (seen_next[1:0] == 2'b11) ? scv_pkg::ST_OK : scv_pkg::ST_MISSING;
                default: stat = scv_pkg::ST_SHORT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            pos_reg <= '0; crc_reg <= '1; shf_reg <= '0; stored_reg <= '0; decl_reg <= '0;
            secs_reg <= '0; ph_reg <= scv_pkg::PH_FILEHDR; ferr_reg <= '0; tag_reg <= '0;
            send_reg <= '0; recs_reg <= '0; roff_reg <= '0; rails_reg <= 1'b0;
            seen_reg <= '0; req_reg <= 1'b0; herr_reg <= '0; lay_reg <= 1'b0;
            maj_reg <= 1'b0; kind_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next; crc_reg <= crc_next; shf_reg <= shf_next;
            stored_reg <= stored_next; decl_reg <= decl_next; secs_reg <= secs_next;
            ph_reg <= ph_next; ferr_reg <= ferr_next; tag_reg <= tag_next;
            send_reg <= send_next; recs_reg <= recs_next; roff_reg <= roff_next;
            rails_reg <= rails_next; seen_reg <= seen_next; req_reg <= req_next;
            herr_reg <= herr_next; lay_reg <= lay_next; maj_reg <= maj_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg  <= scv_pkg::MAX_RESET;
            oval_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) max_reg <= cfg_wr_data;
            if (accept && s_tlast) oval_reg <= 1'b1;
            else if (m_tready) oval_reg <= 1'b0;
        end
        if (accept && s_tlast) out_reg <= {4'd0, ~crc_next, stat};
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_pos_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> pos_reg == 33'd0)
        else $error("position not cleared after last word");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd10)
        else $error("status code out of range");

endmodule
